FILE: src/i2a_pkg.sv
// Shared types, constants and helpers of the integer to ASCII converter.
package i2a_pkg;

   localparam int VALUE_W         = 64;
   localparam int NARROW_W        = 32;
   localparam int DIGIT_W         = 4;
   localparam int CHAR_W          = 7;
   localparam int BIT_CNT_W       = $clog2(VALUE_W + 1);
   localparam int MAX_DIGITS_DEF  = 20;
   localparam int HEX_MIN_DIGITS  = 4;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_HEXA  = 7'h41;
   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               wide;
      logic               hex_mode;
      logic               as_unsigned;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              last_char;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_MOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        dec;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         return CH_ZERO + ext;
      end
      return CH_HEXA + ext - 7'd10;
   endfunction

endpackage

FILE: src/i2a_cell.sv
// One digit cell of the conversion chain: shift-and-adjust or digit move.
module i2a_cell (
   input  logic                         clock,
   input  i2a_pkg::cell_ctrl_type       ctrl,
   input  logic                         low_bit,
   input  logic [i2a_pkg::DIGIT_W-1:0]  low_digit,
   output logic [i2a_pkg::DIGIT_W-1:0]  digit,
   output logic                         carry
);
   import i2a_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // add 3 before the shift when a decimal digit would reach ten or more
   always_comb begin
      adj = (ctrl.dec && digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
      case (ctrl.op)
         CELL_CLEAR:  digit_in = '0;
         CELL_DABBLE: digit_in = {adj[DIGIT_W-2:0], low_bit};
         CELL_MOVE:   digit_in = low_digit;
         default:     digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;
   assign carry = adj[DIGIT_W-1];

endmodule

FILE: src/integer_to_ascii_converter.sv
// Top level of the integer to ASCII converter: sequencer, magnitude shifter, cell chain.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   req     | in        | req_valid/req_stall | value, wide, hex_mode, as_unsigned
//   rsp     | out       | rsp_valid/rsp_stall | char_out, last_char (one char per transfer)
//
// An item runs bit-serial shift-and-add-3 through the digit cell chain over its 32 or 64
// value bits (one value bit per cycle), then drops top digits that do not fit beside the
// sign and leading zero digits (one per cycle), then sends the characters, one each.
// Reset (synchronous, active high) empties the output register and returns to idle.
// A stall on rsp holds the current character; the sequencer waits on it.
// The next item is taken once the last character sits in the output register.
module integer_to_ascii_converter #(
   parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  i2a_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output i2a_pkg::rsp_payload_type rsp_payload
);
   import i2a_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
   localparam logic [CNT_W-1:0] HEX_MIN = CNT_W'(HEX_MIN_DIGITS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   state_type state_ff, state_in;

   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [BIT_CNT_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 hex_ff, hex_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   cell_ctrl_type        ctrl;
   logic [DIGIT_W-1:0]   digits [MAX_DIGITS];
   logic                 carries [MAX_DIGITS];

   logic                 req_xfer;
   logic                 slot_free;
   logic                 load_neg;
   logic [VALUE_W-1:0]   load_mag;
   logic [NARROW_W-1:0]  low_word;
   logic [CNT_W-1:0]     max_dig;
   logic [CNT_W-1:0]     min_dig;
   logic [DIGIT_W-1:0]   top_digit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign top_digit = digits[MAX_DIGITS-1];

   // magnitude and sign of the incoming value; narrow values sit in the upper half
   always_comb begin
      low_word = req_payload.value[NARROW_W-1:0];
      if (req_payload.wide) begin
         load_neg = req_payload.value[VALUE_W-1] && !req_payload.hex_mode;
         load_mag = load_neg ? '0 - req_payload.value : req_payload.value;
      end else begin
         load_neg = low_word[NARROW_W-1] && !req_payload.as_unsigned && !req_payload.hex_mode;
         load_mag = {(load_neg ? '0 - low_word : low_word), {(VALUE_W-NARROW_W){1'b0}}};
      end
   end

   // digits kept after the sign, and the zero-fill floor
   always_comb begin
      max_dig = neg_ff ? MAX_CNT - ONE_CNT : MAX_CNT;
      if (hex_ff) begin
         min_dig = (HEX_MIN > max_dig) ? max_dig : HEX_MIN;
      end else begin
         min_dig = ONE_CNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      bits_ff        <= bits_in;
      cnt_ff         <= cnt_in;
      neg_ff         <= neg_in;
      hex_ff         <= hex_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      state_in       = state_ff;
      mag_in         = mag_ff;
      bits_in        = bits_ff;
      cnt_in         = cnt_ff;
      neg_in         = neg_ff;
      hex_in         = hex_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      ctrl.op        = CELL_HOLD;
      ctrl.dec       = !hex_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mag_in   = load_mag;
               bits_in  = req_payload.wide ? BIT_CNT_W'(VALUE_W) : BIT_CNT_W'(NARROW_W);
               cnt_in   = MAX_CNT;
               neg_in   = load_neg;
               hex_in   = req_payload.hex_mode;
               ctrl.op  = CELL_CLEAR;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // one magnitude bit a cycle enters the bottom cell
            ctrl.op = CELL_DABBLE;
            mag_in  = {mag_ff[VALUE_W-2:0], 1'b0};
            bits_in = bits_ff - 1'b1;
            if (bits_ff == BIT_CNT_W'(1)) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop top digits that do not fit beside the sign
            if (cnt_ff > max_dig) begin
               ctrl.op = CELL_MOVE;
               cnt_in  = cnt_ff - ONE_CNT;
            end else begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (cnt_ff > min_dig && top_digit == '0) begin
               ctrl.op = CELL_MOVE;
               cnt_in  = cnt_ff - ONE_CNT;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.char_out  = CH_MINUS;
               rsp_payload_in.last_char = 1'b0;
               state_in                 = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // emit the top digit and advance the chain upward
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.char_out  = digit_to_char(top_digit);
               rsp_payload_in.last_char = (cnt_ff == ONE_CNT);
               ctrl.op                  = CELL_MOVE;
               cnt_in                   = cnt_ff - ONE_CNT;
               if (cnt_ff == ONE_CNT) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // digit chain: cell 0 is least significant, carries and digits move upward
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         i2a_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .low_bit   (mag_ff[VALUE_W-1]),
            .low_digit ('0),
            .digit     (digits[i]),
            .carry     (carries[i])
         );
      end else begin : g_next
         i2a_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .low_bit   (carries[i-1]),
            .low_digit (digits[i-1]),
            .digit     (digits[i]),
            .carry     (carries[i])
         );
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: src/i2a_checker.sv
// Port-level checker of the integer to ASCII converter and its bind.
module i2a_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input i2a_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input i2a_pkg::rsp_payload_type rsp_payload
);
   import i2a_pkg::*;

   logic req_xfer;
   logic minus_xfer;

   assign req_xfer   = req_valid && !req_stall;
   assign minus_xfer = rsp_valid && !rsp_stall && rsp_payload.char_out == CH_MINUS;

   // hold a stalled character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // a conversion keeps the input closed on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("input taken while converting");

   // a minus sign never ends a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.char_out == CH_MINUS |-> !rsp_payload.last_char)
      else $error("minus sign flagged last");

   // only sign, decimal digit or upper-case hex letter leave the block
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.char_out == CH_MINUS)
                 || (rsp_payload.char_out >= CH_ZERO && rsp_payload.char_out <= 7'h39)
                 || (rsp_payload.char_out >= CH_HEXA && rsp_payload.char_out <= 7'h46))
      else $error("character outside output set");

   // no second minus right after a minus transfer
   a_single_minus: assert property (@(posedge clock) disable iff (reset)
      minus_xfer |=> !(rsp_valid && rsp_payload.char_out == CH_MINUS))
      else $error("repeated minus sign");

endmodule

bind integer_to_ascii_converter i2a_checker u_i2a_checker (.*);

FILE: test/integer_to_ascii_converter_tb.sv
// Testbench for the integer to ASCII converter: directed and random numbers checked char by char.
`timescale 1ns / 100ps

module tb;
   import i2a_pkg::*;

   // Cap on characters per number. It stays at the block's default; a minus sign with 19 digits reaches it.
   localparam int CHAR_CAP       = MAX_DIGITS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   // In one conversion, dropped zeros and characters together never pass 21. Let the tail
   // run on past the end of the last conversion.
   localparam int TAIL_CYCLES    = 150;
   localparam int RANDOM_ITEMS   = 440;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef enum int {
      SHAPE_FULL,
      SHAPE_SHIFTED,
      SHAPE_TINY,
      SHAPE_NEG_TINY,
      SHAPE_DECADE,
      SHAPE_EDGE,
      SHAPE_NIBBLES
   } shape_type;

   // Predict the text of each accepted number and check the characters as they arrive.
   class ascii_scoreboard;
      rsp_payload_type expected_chars[$];
      int unsigned     errors;
      int unsigned     numbers;
      int unsigned     wide_numbers;
      int unsigned     hex_numbers;
      int unsigned     minus_numbers;
      int unsigned     checked_chars;

      function void note_number(input req_payload_type p);
         logic [63:0]     mag;
         logic [31:0]     lo;
         logic [63:0]     radix;
         logic            minus;
         logic [3:0]      digits [CHAR_CAP];
         logic [3:0]      d;
         int unsigned     max_dig;
         int unsigned     min_dig;
         int unsigned     count;
         rsp_payload_type c;
         minus = 1'b0;
         radix = p.hex_mode ? 64'd16 : 64'd10;
         lo    = p.value[31:0];
         if (p.wide) begin
            // 64-bit decimal values are signed whatever as_unsigned says.
            minus = !p.hex_mode && p.value[63];
            mag   = minus ? -p.value : p.value;
         end else begin
            // Ignore the upper half. Hex prints the raw two's complement bits.
            minus = !p.as_unsigned && !p.hex_mode && lo[31];
            mag   = {32'd0, (minus ? -lo : lo)};
         end
         max_dig = minus ? CHAR_CAP - 1 : CHAR_CAP;
         if (max_dig < 1) max_dig = 1;
         min_dig = p.hex_mode ? HEX_MIN_DIGITS : 1;
         if (min_dig > max_dig) min_dig = max_dig;
         count = 0;
         do begin
            digits[count] = 4'(mag % radix);
            mag           = mag / radix;
            count++;
         end while (mag != 0 && count < max_dig);
         // Pad hex with leading zeros.
         while (count < min_dig) begin
            digits[count] = 4'd0;
            count++;
         end
         if (minus) begin
            c.char_out  = CH_MINUS;
            c.last_char = 1'b0;
            expected_chars.push_back(c);
         end
         for (int k = count; k > 0; k--) begin
            d           = digits[k-1];
            c.char_out  = (d < 4'd10) ? CH_ZERO + 7'(d) : CH_HEXA + 7'(d) - 7'd10;
            c.last_char = (k == 1);
            expected_chars.push_back(c);
         end
         numbers++;
         if (p.wide) wide_numbers++;
         if (p.hex_mode) hex_numbers++;
         if (minus) minus_numbers++;
      endfunction

      function void check_char(input rsp_payload_type got);
         rsp_payload_type want;
         checked_chars++;
         if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("MISMATCH char %0d: nothing pending, got char %h last %b",
                        checked_chars, got.char_out, got.last_char);
            return;
         end
         want = expected_chars.pop_front();
         if (got.char_out !== want.char_out || got.last_char !== want.last_char) begin
            errors++;
            if (errors <= 10)
               $display("MISMATCH char %0d: expected char %h last %b, got char %h last %b",
                        checked_chars, want.char_out, want.last_char,
                        got.char_out, got.last_char);
         end
      endfunction

      function int unsigned pending();
         return expected_chars.size();
      endfunction

      function void close();
         if (expected_chars.size() != 0) begin
            errors += expected_chars.size();
            $display("MISSING: %0d characters never arrived", expected_chars.size());
         end
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   ascii_scoreboard sb;
   int unsigned     burst_left   = 1;
   int unsigned     idle_cycles  = 0;
   stall_mode_type  stall_mode   = STALL_NONE;
   int unsigned     stall_span   = 0;
   int unsigned     stall_phase  = 0;

   wire req_xfer = req_valid && !req_stall;
   wire rsp_xfer = rsp_valid && !rsp_stall;

   integer_to_ascii_converter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: switch between stall modes after each random span so that stalls hit
   // every character position, with calm stretches in between.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(16, 160);
      end else begin
         stall_span <= stall_span - 1;
      end
      stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_phase == 0);
      endcase
   end

   // Check each result transfer against the oldest predicted character.
   always @(posedge clock) begin
      if (!reset && rsp_xfer) begin
         sb.check_char(rsp_payload);
      end
   end

   // Watchdog: end the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || req_xfer || rsp_xfer) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
         end
      end
   end

   function automatic req_payload_type make_req(input logic [63:0] v, input logic w,
                                                input logic h, input logic u);
      req_payload_type p;
      p.value       = v;
      p.wide        = w;
      p.hex_mode    = h;
      p.as_unsigned = u;
      return p;
   endfunction

   // Offer one number and hold it until the transfer. Between bursts drop valid
   // for a random gap; a gap of zero keeps valid high into the next burst.
   task automatic push_item(input req_payload_type p);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_number(p);
      if (burst_left <= 1) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Hold off the sender until every predicted character has arrived.
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      // 32-bit signed decimal; the upper half of value is junk and must be ignored.
      push_item(make_req(64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b0));
      push_item(make_req(64'hFFFF_FFFF_0000_0001, 1'b0, 1'b0, 1'b0));
      push_item(make_req(64'hDEAD_BEEF_FFFF_FFFF, 1'b0, 1'b0, 1'b0));
      push_item(make_req(64'h1234_5678_7FFF_FFFF, 1'b0, 1'b0, 1'b0));
      // most negative 32-bit value
      push_item(make_req(64'h0000_0000_8000_0000, 1'b0, 1'b0, 1'b0));
      // 32-bit unsigned decimal
      push_item(make_req(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 1'b1));
      push_item(make_req(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 1'b1));
      // 32-bit hex: zero fill, negative without a sign
      push_item(make_req(64'h0000_0000_0000_0000, 1'b0, 1'b1, 1'b0));
      push_item(make_req(64'hA5A5_A5A5_0000_0005, 1'b0, 1'b1, 1'b0));
      push_item(make_req(64'h0000_0000_ABCD_EF12, 1'b0, 1'b1, 1'b0));
      push_item(make_req(64'h0000_0000_0001_2345, 1'b0, 1'b1, 1'b0));
      push_item(make_req(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b1, 1'b1));
      // 64-bit decimal, including the most negative value
      push_item(make_req(64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0));
      push_item(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0));
      push_item(make_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0));
      push_item(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0));
      push_item(make_req(64'd1234567890123456789, 1'b1, 1'b0, 1'b0));
      // as_unsigned has no effect on 64-bit values
      push_item(make_req(-64'd9, 1'b1, 1'b0, 1'b1));
      // 64-bit hex
      push_item(make_req(64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0));
      push_item(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0));
      push_item(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1));
      push_item(make_req(64'h0000_0000_0000_0123, 1'b1, 1'b1, 1'b0));
      push_item(make_req(64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, 1'b0));
      push_item(make_req(64'h0000_0001_0000_0000, 1'b1, 1'b1, 1'b0));
   endtask

   task automatic run_random(input int unsigned count);
      logic [63:0] v;
      logic [63:0] decade;
      logic        w;
      logic        h;
      logic        u;
      shape_type   shape;
      for (int i = 0; i < count; i++) begin
         v     = {$urandom, $urandom};
         w     = $urandom_range(0, 1);
         h     = $urandom_range(0, 1);
         u     = $urandom_range(0, 1);
         shape = shape_type'($urandom_range(0, 6));
         case (shape)
            SHAPE_FULL:     ;
            SHAPE_SHIFTED:  v = v >> $urandom_range(1, 63);
            SHAPE_TINY:     v = 64'($urandom_range(0, 20));
            SHAPE_NEG_TINY: v = -64'($urandom_range(1, 20));
            SHAPE_DECADE: begin
               // Hit digit-count boundaries: a power of ten, one less or one more.
               decade = 64'd1;
               repeat ($urandom_range(0, 19)) decade = decade * 64'd10;
               v = decade + 64'($urandom_range(0, 2)) - 64'd1;
               if ($urandom_range(0, 1)) v = -v;
            end
            SHAPE_EDGE: begin
               case ($urandom_range(0, 2))
                  0: v = 64'h8000_0000_0000_0000;
                  1: v = 64'h7FFF_FFFF_FFFF_FFFF;
                  default: v = 64'hFFFF_FFFF_FFFF_FFFF;
               endcase
               if (!w) v[31:0] = v[63:32];
            end
            default:        v = v >> (4 * $urandom_range(0, 15));
         endcase
         // Fill the unused upper half with junk for 32-bit items.
         if (!w && shape != SHAPE_FULL) v[63:32] = $urandom;
         push_item(make_req(v, w, h, u));
         if ($urandom_range(0, 99) == 0) drain();
      end
   endtask

   initial begin
      sb = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      // Let the block go fully idle once before the random part.
      drain();
      run_random(RANDOM_ITEMS);
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close();
      $display("Converted %0d numbers (%0d 64-bit, %0d hex, %0d with a minus sign),",
               sb.numbers, sb.wide_numbers, sb.hex_numbers, sb.minus_numbers);
      $display("checked %0d characters with %0d errors.", sb.checked_chars, sb.errors);
      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/i2a_pkg.sv
src/i2a_cell.sv
src/integer_to_ascii_converter.sv
src/i2a_checker.sv
test/integer_to_ascii_converter_tb.sv
